// ===== src/dclvsq_pkg.sv =====
// shared constants, types and codes for the dc-link voltage-squared pi controller
// no dependencies; used by dclvsq_ctrl, dclvsq_datapath and dc_link_voltage_squared_pi
package dclvsq_pkg;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // field and register widths
    localparam int VOLT_WIDTH  = 21;
    localparam int INTEG_WIDTH = 48;
    localparam int SP_WIDTH    = 20;
    localparam int GAIN_WIDTH  = 32;
    localparam int STEP_WIDTH  = 16;
    localparam int PREF_WIDTH  = 32;
    localparam int MODE_WIDTH  = 2;
    localparam int CIDX_WIDTH  = 2;

    localparam int FRAC_BITS = 24;
    localparam int SQ_SHIFT  = 20;

    localparam logic [SP_WIDTH-1:0]   SP_RESET   = SP_WIDTH'(600000);
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(2);

    // derived datapath widths
    localparam int SQS_W = 2 * SP_WIDTH - SQ_SHIFT;
    localparam int SQM_W = 2 * VOLT_WIDTH - SQ_SHIFT;
    localparam int ERR_W = max_i(SQS_W, SQM_W) + 1;
    localparam int MA_W  = max_i(max_i(VOLT_WIDTH, SP_WIDTH), ERR_W) + 1;
    localparam int MB_W  = max_i(max_i(VOLT_WIDTH, SP_WIDTH), GAIN_WIDTH) + 1;
    localparam int MP_W  = MA_W + MB_W;
    localparam int GM_W  = MP_W - FRAC_BITS;
    localparam int SUM_W = max_i(GM_W, INTEG_WIDTH) + 2;

    // configuration register indexes
    typedef enum logic [CIDX_WIDTH-1:0] {
        REG_KP_GAIN   = 2'd0,
        REG_KI_TS     = 2'd1,
        REG_RAMP_STEP = 2'd2
    } reg_idx_t;

    // mode codes
    localparam logic [MODE_WIDTH-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_INTEG = 2'd1;

    // shared multiplier operations
    typedef enum logic [1:0] {
        OP_SQ_SP   = 2'd0,
        OP_SQ_MEAS = 2'd1,
        OP_KP      = 2'd2,
        OP_KI      = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    accept;     // latch input word, ramp setpoint
        logic    op_en;      // run shared multiplier and store its result
        mul_op_t op;
        logic    load_out;   // form saturated power reference
        logic    integ_upd;  // apply integrator increment
    } cmd_t;

    typedef struct packed {
        logic integrate;     // latched mode asks for integration
    } status_t;

endpackage

// ===== src/dclvsq_ctrl.sv =====
// sequencer for the dc-link voltage-squared pi controller
// depends on dclvsq_pkg; drives the command struct of dclvsq_datapath
module dclvsq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dclvsq_pkg::status_t status,
    output dclvsq_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SQ_SP   = 6'b000010,
        ST_SQ_MEAS = 6'b000100,
        ST_PROP    = 6'b001000,
        ST_KI      = 6'b010000,
        ST_UPD     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_UPD);
    assign accept   = s_tready && s_tvalid;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.op        = dclvsq_pkg::OP_SQ_SP;
        cmd.accept    = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_SQ_SP;
            end
            ST_SQ_SP: begin
                cmd.op_en  = 1'b1;
                cmd.op     = dclvsq_pkg::OP_SQ_SP;
                state_next = ST_SQ_MEAS;
            end
            ST_SQ_MEAS: begin
                cmd.op_en  = 1'b1;
                cmd.op     = dclvsq_pkg::OP_SQ_MEAS;
                state_next = ST_PROP;
            end
            ST_PROP: begin
                cmd.op_en  = 1'b1;
                cmd.op     = dclvsq_pkg::OP_KP;
                state_next = ST_KI;
            end
            ST_KI: begin
                // wait here while the previous result is still unclaimed
                cmd.op = dclvsq_pkg::OP_KI;
                if (out_free) begin
                    cmd.op_en    = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.integ_upd = status.integrate;
                state_next    = accept ? ST_SQ_SP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/dclvsq_datapath.sv =====
// datapath: config registers, setpoint ramp, shared multiplier, integrator, output
// depends on dclvsq_pkg; sequenced by dclvsq_ctrl through the command struct
module dclvsq_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [dclvsq_pkg::CIDX_WIDTH-1:0]     cfg_index,
    input  logic [dclvsq_pkg::GAIN_WIDTH-1:0]     cfg_data,
    input  logic [dclvsq_pkg::SP_WIDTH-1:0]       target_voltage,
    input  logic signed [dclvsq_pkg::VOLT_WIDTH-1:0] measured_voltage,
    input  logic [dclvsq_pkg::MODE_WIDTH-1:0]     mode,
    input  dclvsq_pkg::cmd_t                      cmd,
    output dclvsq_pkg::status_t                   status,
    output logic [dclvsq_pkg::PREF_WIDTH-1:0]     power_reference,
    output logic [dclvsq_pkg::SP_WIDTH-1:0]       ramped_setpoint
);

    localparam int VW  = dclvsq_pkg::VOLT_WIDTH;
    localparam int SPW = dclvsq_pkg::SP_WIDTH;
    localparam int IW  = dclvsq_pkg::INTEG_WIDTH;
    localparam int PW  = dclvsq_pkg::PREF_WIDTH;
    localparam int GW  = dclvsq_pkg::GAIN_WIDTH;
    localparam int SW  = dclvsq_pkg::STEP_WIDTH;
    localparam int EW  = dclvsq_pkg::ERR_W;
    localparam int AW  = dclvsq_pkg::MA_W;
    localparam int BW  = dclvsq_pkg::MB_W;
    localparam int PRW = dclvsq_pkg::MP_W;
    localparam int GMW = dclvsq_pkg::GM_W;
    localparam int UW  = dclvsq_pkg::SUM_W;
    localparam int FB  = dclvsq_pkg::FRAC_BITS;
    localparam int SQS = dclvsq_pkg::SQS_W;
    localparam int SQM = dclvsq_pkg::SQM_W;
    localparam int SH  = dclvsq_pkg::SQ_SHIFT;

    localparam logic signed [UW-1:0] PREF_MAX = {{(UW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [UW-1:0] PREF_MIN = {{(UW-PW+1){1'b1}}, {(PW-1){1'b0}}};
    localparam logic signed [UW-1:0] INTEG_MAX = {{(UW-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [UW-1:0] INTEG_MIN = {{(UW-IW+1){1'b1}}, {(IW-1){1'b0}}};

    // configuration
    logic [GW-1:0] kp_gain_reg, ki_ts_reg;
    logic [SW-1:0] ramp_step_reg;

    // per-sample state
    logic [SPW-1:0]           sp_reg, sp_next;
    logic [VW-1:0]            mag_reg, mag_next;
    logic [dclvsq_pkg::MODE_WIDTH-1:0] mode_reg;
    logic [SQS-1:0]           sq_sp_reg;
    logic [SQM-1:0]           sq_meas_reg;
    logic signed [GMW-1:0]    prop_reg, inc_reg;
    logic signed [IW-1:0]     integ_reg;
    logic [PW-1:0]            pref_reg;
    logic [SPW-1:0]           sp_out_reg;

    logic signed [EW-1:0]     err;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [PRW-1:0]    mul_p;
    logic signed [UW-1:0]     out_sum, out_sat;
    logic signed [UW-1:0]     integ_sum, integ_sat;
    logic [SPW:0]             sp_up;
    logic [SPW-1:0]           sp_diff;

    // ramp toward the target without overshooting it
    always_comb begin
        sp_up   = {1'b0, sp_reg} + (SPW+1)'(ramp_step_reg);
        sp_diff = sp_reg - target_voltage;
        sp_next = sp_reg;
        if (target_voltage > sp_reg) begin
            sp_next = (sp_up > {1'b0, target_voltage}) ? target_voltage : sp_up[SPW-1:0];
        end else if (target_voltage < sp_reg) begin
            sp_next = (sp_diff > SPW'(ramp_step_reg)) ? sp_reg - SPW'(ramp_step_reg)
                                                      : target_voltage;
        end
    end

    // magnitude; the most negative code maps to its true magnitude
    assign mag_next = measured_voltage[VW-1] ? VW'(-measured_voltage) : measured_voltage;

    assign err = $signed(EW'(sq_sp_reg)) - $signed(EW'(sq_meas_reg));

    always_comb begin
        case (cmd.op)
            dclvsq_pkg::OP_SQ_SP: begin
                mul_a = $signed({{(AW-SPW){1'b0}}, sp_reg});
                mul_b = $signed({{(BW-SPW){1'b0}}, sp_reg});
            end
            dclvsq_pkg::OP_SQ_MEAS: begin
                mul_a = $signed({{(AW-VW){1'b0}}, mag_reg});
                mul_b = $signed({{(BW-VW){1'b0}}, mag_reg});
            end
            dclvsq_pkg::OP_KP: begin
                mul_a = $signed({{(AW-EW){err[EW-1]}}, err});
                mul_b = $signed({{(BW-GW){1'b0}}, kp_gain_reg});
            end
            dclvsq_pkg::OP_KI: begin
                mul_a = $signed({{(AW-EW){err[EW-1]}}, err});
                mul_b = $signed({{(BW-GW){1'b0}}, ki_ts_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // p_ref = -(p + i), saturated
    always_comb begin
        out_sum = -(UW'(prop_reg) + UW'(integ_reg));
        if (out_sum > PREF_MAX) begin
            out_sat = PREF_MAX;
        end else if (out_sum < PREF_MIN) begin
            out_sat = PREF_MIN;
        end else begin
            out_sat = out_sum;
        end
    end

    // saturating integrator update
    always_comb begin
        integ_sum = UW'(integ_reg) + UW'(inc_reg);
        if (integ_sum > INTEG_MAX) begin
            integ_sat = INTEG_MAX;
        end else if (integ_sum < INTEG_MIN) begin
            integ_sat = INTEG_MIN;
        end else begin
            integ_sat = integ_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg   <= '0;
            ki_ts_reg     <= '0;
            ramp_step_reg <= dclvsq_pkg::STEP_RESET;
            sp_reg        <= dclvsq_pkg::SP_RESET;
            integ_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    dclvsq_pkg::REG_KP_GAIN:   kp_gain_reg   <= cfg_data;
                    dclvsq_pkg::REG_KI_TS:     ki_ts_reg     <= cfg_data;
                    dclvsq_pkg::REG_RAMP_STEP: ramp_step_reg <= cfg_data[SW-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.accept) begin
                sp_reg <= sp_next;
            end
            // a clear from the next word wins over the pending update
            if (cmd.accept && mode == dclvsq_pkg::MODE_CLEAR) begin
                integ_reg <= '0;
            end else if (cmd.integ_upd) begin
                integ_reg <= integ_sat[IW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mag_reg  <= mag_next;
            mode_reg <= mode;
        end
        if (cmd.op_en) begin
            case (cmd.op)
                dclvsq_pkg::OP_SQ_SP:   sq_sp_reg   <= mul_p[SH +: SQS];
                dclvsq_pkg::OP_SQ_MEAS: sq_meas_reg <= mul_p[SH +: SQM];
                dclvsq_pkg::OP_KP:      prop_reg    <= mul_p[PRW-1:FB];
                dclvsq_pkg::OP_KI:      inc_reg     <= mul_p[PRW-1:FB];
                default: begin
                end
            endcase
        end
        // setpoint is held with the power reference while the word waits
        if (cmd.load_out) begin
            pref_reg   <= out_sat[PW-1:0];
            sp_out_reg <= sp_reg;
        end
    end

    assign status.integrate = (mode_reg == dclvsq_pkg::MODE_INTEG);
    assign power_reference  = pref_reg;
    assign ramped_setpoint  = sp_out_reg;

endmodule

// ===== src/dc_link_voltage_squared_pi.sv =====
// top level of the dc-link voltage-squared pi controller with ramped setpoint
// depends on dclvsq_pkg, dclvsq_ctrl and dclvsq_datapath
//
//  port group   | dir | word contents
//  -------------+-----+--------------------------------------------------------
//  s_ (input)   | in  | tdata: target_voltage, measured_voltage; tuser: mode
//  m_ (result)  | out | tdata: power_reference, ramped_setpoint
//  cfg_         | in  | cfg_index selects kp_gain / ki_ts_gain / ramp_step
//
// an input word is handled in steps: one shared 24x33 signed multiplier runs the
// setpoint square, the measurement square, the kp product and the ki product in turn,
// then the integrator is updated; the next word can already be taken in that update cycle
// the result sits in an output register, so a new word is accepted while it waits;
// only the ki step stalls if the previous result has still not been taken
// reset (aresetn low, synchronous) sets the setpoint to 600 V, clears the integrator
// and the gains and sets ramp_step to 2; config writes are always accepted
module dc_link_voltage_squared_pi (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [19:0] target_voltage, [40:20] measured_voltage, rest 0
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [31:0] power_reference, [51:32] ramped_setpoint, rest 0
);

    localparam int SPW = dclvsq_pkg::SP_WIDTH;
    localparam int VW  = dclvsq_pkg::VOLT_WIDTH;
    localparam int PW  = dclvsq_pkg::PREF_WIDTH;

    dclvsq_pkg::cmd_t    cmd;
    dclvsq_pkg::status_t status;

    logic [PW-1:0]  power_reference;
    logic [SPW-1:0] ramped_setpoint;

    // the user must write registers only while idle; not enforced, so writes never wait
    assign cfg_ready = 1'b1;

    dclvsq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dclvsq_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .target_voltage   (s_tdata[SPW-1:0]),
        .measured_voltage ($signed(s_tdata[SPW +: VW])),
        .mode             (s_tuser),
        .cmd              (cmd),
        .status           (status),
        .power_reference  (power_reference),
        .ramped_setpoint  (ramped_setpoint)
    );

    // pack result word, zero fill to whole bytes
    assign m_tdata = {{(56-PW-SPW){1'b0}}, ramped_setpoint, power_reference};

endmodule

// ===== tb/dc_link_voltage_squared_pi_tb.sv =====
// self-checking bench for the dc-link voltage-squared pi controller (dc_link_voltage_squared_pi)
// depends on dclvsq_pkg for widths, reset values, mode codes and register indexes
// a cycle-free controller model predicts every result word, checked in order at the m_ side
`timescale 1ns / 1ps

module dc_link_voltage_squared_pi_tb;

    localparam int VOLT_WIDTH  = dclvsq_pkg::VOLT_WIDTH;
    localparam int INTEG_WIDTH = dclvsq_pkg::INTEG_WIDTH;
    localparam int SP_WIDTH    = dclvsq_pkg::SP_WIDTH;
    localparam int GAIN_WIDTH  = dclvsq_pkg::GAIN_WIDTH;
    localparam int STEP_WIDTH  = dclvsq_pkg::STEP_WIDTH;
    localparam int PREF_WIDTH  = dclvsq_pkg::PREF_WIDTH;
    localparam int MODE_WIDTH  = dclvsq_pkg::MODE_WIDTH;
    localparam int FRAC_BITS   = dclvsq_pkg::FRAC_BITS;
    localparam int SQ_SHIFT    = dclvsq_pkg::SQ_SHIFT;

    localparam logic [SP_WIDTH-1:0]   SP_RESET   = dclvsq_pkg::SP_RESET;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = dclvsq_pkg::STEP_RESET;
    localparam logic [MODE_WIDTH-1:0] MODE_CLEAR = dclvsq_pkg::MODE_CLEAR;
    localparam logic [MODE_WIDTH-1:0] MODE_INTEG = dclvsq_pkg::MODE_INTEG;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_WORDS  = 240;

    // modes without a package name: hold, and the unused code that also holds
    localparam logic [MODE_WIDTH-1:0] MODE_HOLD  = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;

    localparam logic [VOLT_WIDTH-1:0] MEAS_MIN = {1'b1, {(VOLT_WIDTH-1){1'b0}}};
    localparam logic [VOLT_WIDTH-1:0] MEAS_MAX = {1'b0, {(VOLT_WIDTH-1){1'b1}}};
    localparam logic [SP_WIDTH-1:0]   SP_MAX   = '1;

    localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint PREF_MAX  = (longint'(1) <<< (PREF_WIDTH - 1)) - 1;
    localparam longint PREF_MIN  = -PREF_MAX - 1;

    typedef struct packed {
        logic [SP_WIDTH-1:0]   target;
        logic [VOLT_WIDTH-1:0] meas;
        logic [MODE_WIDTH-1:0] mode;
    } sample_t;

    typedef struct packed {
        logic [PREF_WIDTH-1:0] pref;
        logic [SP_WIDTH-1:0]   setpoint;
    } ctrl_out_t;

    // dut connections; every input starts at a known value
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    dclvsq_pkg::reg_idx_t cfg_index = dclvsq_pkg::REG_KP_GAIN;
    logic [31:0]          cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;

    dc_link_voltage_squared_pi u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // samples waiting for the driver, and result words the model expects next
    sample_t   sample_q[$];
    ctrl_out_t pending_refs[$];

    int src_idle_pct = 19;
    int snk_idle_pct = 51;

    int mismatch_cnt  = 0;
    int words_checked = 0;
    int samples_sent  = 0;
    int settings_used = 0;
    int cycle_cnt     = 0;

    // controller model state, reset values as after aresetn
    logic [SP_WIDTH-1:0]   sp_model    = SP_RESET;
    logic [STEP_WIDTH-1:0] step_model  = STEP_RESET;
    logic [GAIN_WIDTH-1:0] kp_model    = '0;
    logic [GAIN_WIDTH-1:0] ki_model    = '0;
    longint                integ_model = 0;

    // exact error times gain, 24 fractional bits dropped toward minus infinity
    function automatic longint scale_by_gain(input longint err, input logic [GAIN_WIDTH-1:0] g);
        longint gv;
        gv = g;
        return (err * gv) >>> FRAC_BITS;
    endfunction

    // one control sample: ramp, squared-voltage error, p + i, integrator update
    function automatic ctrl_out_t predict_power_ref(input sample_t smp);
        longint    meas_v;
        longint    sp_v;
        longint    err;
        longint    prop;
        longint    total;
        longint    inc;
        longint    sp_next;
        ctrl_out_t res;
        if (smp.mode == MODE_CLEAR) begin
            integ_model = 0;
        end
        // ramp toward target, landing exactly on it
        if (smp.target > sp_model) begin
            sp_next = longint'(sp_model) + longint'(step_model);
            sp_model = (sp_next > longint'(smp.target)) ? smp.target : sp_next[SP_WIDTH-1:0];
        end else if (smp.target < sp_model) begin
            sp_model = ((sp_model - smp.target) > step_model) ? sp_model - step_model
                                                                : smp.target;
        end
        meas_v = $signed(smp.meas);
        if (meas_v < 0) begin
            meas_v = -meas_v;
        end
        sp_v = sp_model;
        err = ((sp_v * sp_v) >>> SQ_SHIFT) - ((meas_v * meas_v) >>> SQ_SHIFT);
        prop = scale_by_gain(err, kp_model);
        total = -(prop + integ_model);
        if (total > PREF_MAX) begin
            total = PREF_MAX;
        end else if (total < PREF_MIN) begin
            total = PREF_MIN;
        end
        // integrate after the output is formed, saturating at the accumulator limits
        if (smp.mode == MODE_INTEG) begin
            inc = scale_by_gain(err, ki_model);
            if (inc > 0 && integ_model > INTEG_MAX - inc) begin
                integ_model = INTEG_MAX;
            end else if (inc < 0 && integ_model < INTEG_MIN - inc) begin
                integ_model = INTEG_MIN;
            end else begin
                integ_model = integ_model + inc;
            end
        end
        res.pref     = total[PREF_WIDTH-1:0];
        res.setpoint = sp_model;
        return res;
    endfunction

    // input driver: holds a word until taken, random gaps between words
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, sample_q[0].meas, sample_q[0].target};
                    s_tuser  <= sample_q[0].mode;
                    void'(sample_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            // result side back-pressure
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor: config writes and accepted samples feed the model, result words are checked
    ctrl_out_t got_w;
    ctrl_out_t exp_w;
    sample_t   taken_w;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d words still expected",
                     $realtime, cycle_cnt, pending_refs.size());
            $display("== FAIL ==");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dclvsq_pkg::REG_KP_GAIN: begin
                        kp_model = cfg_data;
                    end
                    dclvsq_pkg::REG_KI_TS: begin
                        ki_model = cfg_data;
                    end
                    dclvsq_pkg::REG_RAMP_STEP: begin
                        step_model = cfg_data[STEP_WIDTH-1:0];
                    end
                    default: ;
                endcase
            end
            // check the outgoing word before queuing the new prediction
            if (m_tvalid && m_tready) begin
                words_checked++;
                got_w.pref     = m_tdata[PREF_WIDTH-1:0];
                got_w.setpoint = m_tdata[32 +: SP_WIDTH];
                if (pending_refs.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t unexpected result word: expected none, got pref %0d sp %0d",
                             $realtime, $signed(got_w.pref), got_w.setpoint);
                end else begin
                    exp_w = pending_refs.pop_front();
                    if (got_w.pref !== exp_w.pref) begin
                        mismatch_cnt++;
                        $display("%0t power_reference: expected %0d, got %0d", $realtime,
                                 $signed(exp_w.pref), $signed(got_w.pref));
                    end
                    if (got_w.setpoint !== exp_w.setpoint) begin
                        mismatch_cnt++;
                        $display("%0t ramped_setpoint: expected %0d, got %0d", $realtime,
                                 exp_w.setpoint, got_w.setpoint);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                taken_w.target = s_tdata[SP_WIDTH-1:0];
                taken_w.meas   = s_tdata[SP_WIDTH +: VOLT_WIDTH];
                taken_w.mode   = s_tuser;
                pending_refs.push_back(predict_power_ref(taken_w));
                samples_sent++;
            end
        end
    end

    task automatic push_sample(input logic [SP_WIDTH-1:0] tgt,
                               input logic [VOLT_WIDTH-1:0] meas_v,
                               input logic [MODE_WIDTH-1:0] md);
        sample_t smp;
        smp.target = tgt;
        smp.meas   = meas_v;
        smp.mode   = md;
        sample_q.push_back(smp);
    endtask

    // wait at the falling edge so queue and handshake state have settled
    task automatic drain();
        while (sample_q.size() != 0 || s_tvalid || pending_refs.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input dclvsq_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] step);
        write_reg(dclvsq_pkg::REG_KP_GAIN, kp);
        write_reg(dclvsq_pkg::REG_KI_TS, ki);
        write_reg(dclvsq_pkg::REG_RAMP_STEP, step);
        settings_used++;
    endtask

    // mostly regulation runs (clear, then integrate/hold around a target),
    // the rest fully random words
    task automatic queue_random_phase(input int n);
        int                    left;
        int                    run_len;
        int                    k;
        int                    r;
        int                    vm;
        logic [SP_WIDTH-1:0]   tgt;
        logic [MODE_WIDTH-1:0] md;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                push_sample(SP_WIDTH'($urandom), VOLT_WIDTH'($urandom), MODE_WIDTH'($urandom));
                left--;
            end else begin
                tgt = SP_WIDTH'($urandom_range(200000, 1000000));
                run_len = $urandom_range(4, 30);
                for (k = 0; k < run_len && left > 0; k++) begin
                    vm = int'(tgt) + int'($urandom_range(0, 20000)) - 10000;
                    if ($urandom_range(99) < 5) begin
                        vm = -vm;
                    end
                    r = $urandom_range(99);
                    if (k == 0 || r >= 95) begin
                        md = MODE_CLEAR;
                    end else if (r < 65) begin
                        md = MODE_INTEG;
                    end else if (r < 88) begin
                        md = MODE_HOLD;
                    end else begin
                        md = MODE_SPARE;
                    end
                    push_sample(tgt, vm[VOLT_WIDTH-1:0], md);
                    left--;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [MODE_WIDTH-1:0] md_seq [8];
        int i;
        md_seq = '{MODE_INTEG, MODE_HOLD, MODE_SPARE, MODE_CLEAR,
                   MODE_INTEG, MODE_INTEG, MODE_HOLD, MODE_INTEG};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero gains, 2 mV ramp from 600 V
        push_sample(SP_WIDTH'(600001), '0, MODE_INTEG);
        push_sample('0, MEAS_MAX, MODE_HOLD);
        push_sample('0, MEAS_MIN, MODE_SPARE);
        drain();

        // unity kp, largest ramp step: climb to full scale and stop there
        set_gains(32'h0100_0000, 32'h0040_0000, 32'h0000_FFFF);
        for (i = 0; i < 8; i++) begin
            push_sample(SP_MAX, (i % 2 == 0) ? MEAS_MIN : MEAS_MAX, md_seq[i]);
        end
        // step back by less than one ramp step lands on the target
        push_sample(SP_MAX - SP_WIDTH'(10), '0, MODE_INTEG);
        push_sample('0, '1, MODE_INTEG);
        push_sample('0, VOLT_WIDTH'(1), MODE_HOLD);
        drain();

        // zero ramp step freezes the setpoint
        write_reg(dclvsq_pkg::REG_RAMP_STEP, 32'd0);
        push_sample('0, '0, MODE_INTEG);
        push_sample(SP_MAX, MEAS_MAX, MODE_SPARE);
        drain();

        set_gains($urandom, $urandom_range(0, 1 << 20), $urandom_range(1, 2000));
        queue_random_phase(PHASE_WORDS);
        drain();

        // full-scale gains drive the output into saturation
        set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
        queue_random_phase(PHASE_WORDS);
        drain();

        src_idle_pct = 51;
        snk_idle_pct = 19;
        set_gains(32'd0, 32'd0, 32'd0);
        queue_random_phase(PHASE_WORDS);
        drain();

        set_gains($urandom, $urandom, $urandom_range(0, 65535));
        queue_random_phase(PHASE_WORDS);
        drain();

        set_gains(32'h0100_0000, 32'h0001_0000, 32'd100);
        queue_random_phase(PHASE_WORDS);
        drain();

        // back-to-back traffic with no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_gains($urandom, $urandom, $urandom_range(0, 65535));
        queue_random_phase(PHASE_WORDS);
        drain();

        set_gains($urandom_range(0, 1 << 26), $urandom_range(0, 1 << 22),
                  $urandom_range(1, 5000));
        queue_random_phase(PHASE_WORDS);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d samples and %0d result words over %0d gain/ramp settings,",
                 samples_sent, words_checked, settings_used);
        $display("with sender/receiver idling 19/51, 51/19 and none; %0d mismatches",
                 mismatch_cnt);
        if (mismatch_cnt == 0 && pending_refs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
